// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/ftcs_pkg.sv
// types and constants of the flow traffic class scorer
package ftcs_pkg;

    localparam logic [1:0] PROTO_TCP = 2'd1;
    localparam logic [1:0] PROTO_UDP = 2'd2;

    localparam logic [1:0] KIND_UNKNOWN  = 2'd0;
    localparam logic [1:0] KIND_REALTIME = 2'd1;
    localparam logic [1:0] KIND_BULK     = 2'd2;

    localparam logic [2:0] REG_RT_MAX_KBPS     = 3'd0;
    localparam logic [2:0] REG_BULK_FLOOR_KBPS = 3'd1;
    localparam logic [2:0] REG_RT_MIN_PPS      = 3'd2;
    localparam logic [2:0] REG_RT_MAX_PPS      = 3'd3;
    localparam logic [2:0] REG_BULK_THR        = 3'd4;
    localparam logic [2:0] REG_RT_THR          = 3'd5;
    localparam logic [2:0] REG_LARGE_SIZE      = 3'd6;

    localparam logic [31:0] DEFAULT_WINDOW_MS = 32'd1000;
    localparam logic [40:0] SMALL_AVG_BYTES   = 41'd350;
    localparam logic [47:0] ACTIVE_MIN_MS     = 48'd2000;

    typedef struct packed {
        logic [31:0] rt_max_kbps;
        logic [31:0] bulk_floor_kbps;
        logic [31:0] rt_min_pps;
        logic [31:0] rt_max_pps;
        logic [3:0]  bulk_thr;
        logic [3:0]  rt_thr;
        logic [15:0] large_size;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rt_max_kbps:     32'd512,
        bulk_floor_kbps: 32'd4096,
        rt_min_pps:      32'd20,
        rt_max_pps:      32'd500,
        bulk_thr:        4'd5,
        rt_thr:          4'd5,
        large_size:      16'd1000
    };

    typedef struct packed {
        logic [1:0]  protocol;
        logic [47:0] byte_count;
        logic [31:0] packet_count;
        logic [31:0] small_count;
        logic [31:0] large_count;
        logic [31:0] window_len_ms;
        logic [47:0] first_time_ms;
        logic [47:0] last_time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]  protocol;
        logic [47:0] bytes;
        logic [57:0] bytes_x1000;
        logic [41:0] pkts_x1000;
        logic [63:0] rt_rate_lim;
        logic [63:0] bulk_rate_lim;
        logic [63:0] min_pps_w;
        logic [63:0] max_pps_w;
        logic [47:0] size_x_pkts;
        logic        pkts_zero;
        logic        avg_small;
        logic        small_hi;
        logic        small_lo;
        logic        large_hi;
        logic        active_long;
    } prod_t;

    typedef struct packed {
        logic [1:0] traffic_kind;
        logic [3:0] realtime_points;
        logic [3:0] bulk_points;
    } result_t;

endpackage

// File: rtl/ftcs_regs.sv
// configuration registers behind the apb port
module ftcs_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ftcs_pkg::cfg_t    cfg
);

    ftcs_pkg::cfg_t cfg_reg;
    ftcs_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                ftcs_pkg::REG_RT_MAX_KBPS:     cfg_next.rt_max_kbps     = pwdata;
                ftcs_pkg::REG_BULK_FLOOR_KBPS: cfg_next.bulk_floor_kbps = pwdata;
                ftcs_pkg::REG_RT_MIN_PPS:      cfg_next.rt_min_pps      = pwdata;
                ftcs_pkg::REG_RT_MAX_PPS:      cfg_next.rt_max_pps      = pwdata;
                ftcs_pkg::REG_BULK_THR:        cfg_next.bulk_thr        = pwdata[3:0];
                ftcs_pkg::REG_RT_THR:          cfg_next.rt_thr          = pwdata[3:0];
                ftcs_pkg::REG_LARGE_SIZE:      cfg_next.large_size      = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ftcs_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            ftcs_pkg::REG_RT_MAX_KBPS:     prdata = cfg_reg.rt_max_kbps;
            ftcs_pkg::REG_BULK_FLOOR_KBPS: prdata = cfg_reg.bulk_floor_kbps;
            ftcs_pkg::REG_RT_MIN_PPS:      prdata = cfg_reg.rt_min_pps;
            ftcs_pkg::REG_RT_MAX_PPS:      prdata = cfg_reg.rt_max_pps;
            ftcs_pkg::REG_BULK_THR:        prdata = {28'd0, cfg_reg.bulk_thr};
            ftcs_pkg::REG_RT_THR:          prdata = {28'd0, cfg_reg.rt_thr};
            ftcs_pkg::REG_LARGE_SIZE:      prdata = {16'd0, cfg_reg.large_size};
            default:                       prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ftcs_prod.sv
// first stage: products of the rate tests and the narrow ratio tests
module ftcs_prod (
    input  logic              aclk,
    input  logic              load,
    input  ftcs_pkg::item_t   item,
    input  ftcs_pkg::cfg_t    cfg,
    output ftcs_pkg::prod_t   prod
);

    ftcs_pkg::prod_t prod_reg;
    ftcs_pkg::prod_t prod_next;
    logic [31:0]     win;
    logic [47:0]     b;
    logic [31:0]     p;
    logic [41:0]     p_ext;
    logic [57:0]     b_ext;
    logic [34:0]     s5;
    logic [34:0]     l5;
    logic [35:0]     s10;
    logic [35:0]     p3;
    logic [47:0]     span;

    always_comb begin
        b   = item.byte_count;
        p   = item.packet_count;
        win = (item.window_len_ms == 32'd0) ? ftcs_pkg::DEFAULT_WINDOW_MS
                                            : item.window_len_ms;
        // x1000 as 1024 - 16 - 8
        b_ext = {10'd0, b};
        p_ext = {10'd0, p};
        s5    = {3'd0, item.small_count} + {1'b0, item.small_count, 2'd0};
        l5    = {3'd0, item.large_count} + {1'b0, item.large_count, 2'd0};
        s10   = {s5, 1'b0};
        p3    = {4'd0, p} + {3'd0, p, 1'b0};
        span  = item.last_time_ms - item.first_time_ms;

        prod_next.protocol      = item.protocol;
        prod_next.bytes         = b;
        prod_next.bytes_x1000   = (b_ext << 10) - (b_ext << 4) - (b_ext << 3);
        prod_next.pkts_x1000    = (p_ext << 10) - (p_ext << 4) - (p_ext << 3);
        prod_next.rt_rate_lim   = 64'(cfg.rt_max_kbps) * 64'(win);
        prod_next.bulk_rate_lim = 64'(cfg.bulk_floor_kbps) * 64'(win);
        prod_next.min_pps_w     = 64'(cfg.rt_min_pps) * 64'(win);
        prod_next.max_pps_w     = 64'(cfg.rt_max_pps) * 64'(win);
        prod_next.size_x_pkts   = 48'(cfg.large_size) * 48'(p);
        prod_next.pkts_zero     = (p == 32'd0);
        prod_next.avg_small     = (p == 32'd0) ||
                                  (b <= {7'd0, 41'(p) * ftcs_pkg::SMALL_AVG_BYTES});
        prod_next.small_hi      = (p != 32'd0) && ({1'b0, s5} >= p3);
        prod_next.large_hi      = (p != 32'd0) && ({1'b0, l5} >= p3);
        prod_next.small_lo      = (p == 32'd0) || (s10 < p3);
        prod_next.active_long   = (item.last_time_ms > item.first_time_ms) &&
                                  (span >= ftcs_pkg::ACTIVE_MIN_MS);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/ftcs_score.sv
// second stage: wide compares, point sums and the class decision
module ftcs_score (
    input  logic              aclk,
    input  logic              load,
    input  ftcs_pkg::prod_t   prod,
    input  ftcs_pkg::cfg_t    cfg,
    output ftcs_pkg::result_t res
);

    ftcs_pkg::result_t res_reg;
    ftcs_pkg::result_t res_next;
    logic [73:0]       bytes_wide;
    logic [63:0]       pkts_wide;
    logic              rate_low;
    logic              rate_high;
    logic              pps_in_range;
    logic              avg_large;
    logic [3:0]        rt;
    logic [3:0]        bk;

    always_comb begin
        // byte rate limits carry the 1024 factor as a shift
        bytes_wide   = {16'd0, prod.bytes_x1000};
        pkts_wide    = {22'd0, prod.pkts_x1000};
        rate_low     = bytes_wide <= {prod.rt_rate_lim, 10'd0};
        rate_high    = bytes_wide >= {prod.bulk_rate_lim, 10'd0};
        pps_in_range = (pkts_wide >= prod.min_pps_w) && (pkts_wide <= prod.max_pps_w);
        avg_large    = prod.pkts_zero ? (cfg.large_size == 16'd0)
                                      : (prod.bytes >= prod.size_x_pkts);

        rt = {3'd0, prod.protocol == ftcs_pkg::PROTO_UDP}
           + {2'd0, prod.avg_small, 1'b0}
           + {2'd0, prod.small_hi, 1'b0}
           + {2'd0, rate_low, 1'b0}
           + {2'd0, pps_in_range, 1'b0};
        bk = {3'd0, prod.protocol == ftcs_pkg::PROTO_TCP}
           + {2'd0, rate_high, rate_high}
           + {2'd0, prod.large_hi, 1'b0}
           + {2'd0, avg_large, 1'b0}
           + {3'd0, prod.active_long}
           + {3'd0, prod.small_lo};

        res_next.realtime_points = rt;
        res_next.bulk_points     = bk;
        if (bk >= cfg.bulk_thr && bk > rt) begin
            res_next.traffic_kind = ftcs_pkg::KIND_BULK;
        end else if (rt >= cfg.rt_thr && rt > bk) begin
            res_next.traffic_kind = ftcs_pkg::KIND_REALTIME;
        end else begin
            res_next.traffic_kind = ftcs_pkg::KIND_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: rtl/flow_traffic_class_scorer.sv
// an accepted input beat is registered in each stage in turn before its result is valid
// throughput: one beat per cycle unless m_ready stalls the output; input register, product register, result register
// each stage moves on when the one after it is empty or drains, so bubbles close up
// the products of the configured rates and the window set the middle stage
// reset (synchronous, aresetn low) empties the pipeline and restores register defaults
module flow_traffic_class_scorer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_protocol,
    input  logic [47:0] s_byte_count,
    input  logic [31:0] s_packet_count,
    input  logic [31:0] s_small_count,
    input  logic [31:0] s_large_count,
    input  logic [31:0] s_window_len_ms,
    input  logic [47:0] s_first_time_ms,
    input  logic [47:0] s_last_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_traffic_kind,
    output logic [3:0]  m_realtime_points,
    output logic [3:0]  m_bulk_points
);

    ftcs_pkg::cfg_t    cfg;
    ftcs_pkg::item_t   in_reg;
    ftcs_pkg::item_t   in_next;
    ftcs_pkg::prod_t   prod;
    ftcs_pkg::result_t res;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              prod_valid_reg;
    logic              prod_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_adv;
    logic              prod_adv;
    logic              in_load;

    ftcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a stage may take a new beat when it is empty or its beat moves on
    assign out_adv  = !out_valid_reg || m_ready;
    assign prod_adv = !prod_valid_reg || out_adv;
    assign s_ready  = !in_valid_reg || prod_adv;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        in_next.protocol      = s_protocol;
        in_next.byte_count    = s_byte_count;
        in_next.packet_count  = s_packet_count;
        in_next.small_count   = s_small_count;
        in_next.large_count   = s_large_count;
        in_next.window_len_ms = s_window_len_ms;
        in_next.first_time_ms = s_first_time_ms;
        in_next.last_time_ms  = s_last_time_ms;

        in_valid_next   = s_ready  ? s_valid        : in_valid_reg;
        prod_valid_next = prod_adv ? in_valid_reg   : prod_valid_reg;
        out_valid_next  = out_adv  ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg <= in_next;
        end
    end

    ftcs_prod u_prod (
        .aclk (aclk),
        .load (prod_adv && in_valid_reg),
        .item (in_reg),
        .cfg  (cfg),
        .prod (prod)
    );

    ftcs_score u_score (
        .aclk (aclk),
        .load (out_adv && prod_valid_reg),
        .prod (prod),
        .cfg  (cfg),
        .res  (res)
    );

    assign m_valid           = out_valid_reg;
    assign m_traffic_kind    = res.traffic_kind;
    assign m_realtime_points = res.realtime_points;
    assign m_bulk_points     = res.bulk_points;

endmodule

// File: rtl/ftcs_checker.sv
// port-level checks on the result channel, bound to the top level
`include "assert_macros.svh"

module ftcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_traffic_kind,
    input logic [3:0] m_realtime_points,
    input logic [3:0] m_bulk_points
);

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_traffic_kind) && $stable(m_realtime_points) && $stable(m_bulk_points))

    // point sums stay inside what the tests can add up to
    `ASSERT_IMPL(a_points_range, aclk, aresetn, m_valid, m_realtime_points <= 4'd9 && m_bulk_points <= 4'd10)

    // a class is given only to the strictly larger score
    `ASSERT_IMPL(a_bulk_wins, aclk, aresetn, m_valid && m_traffic_kind == ftcs_pkg::KIND_BULK, m_bulk_points > m_realtime_points)

    `ASSERT_IMPL(a_rt_wins, aclk, aresetn, m_valid && m_traffic_kind == ftcs_pkg::KIND_REALTIME, m_realtime_points > m_bulk_points)

endmodule

bind flow_traffic_class_scorer ftcs_checker u_ftcs_checker (.*);
